### sv/shrink_then_linear_convolution_assert.svh
// Assertion macros for the shrink-then-convolve block.
// Included by the top level; no other dependencies.
`ifndef SHRINK_THEN_LINEAR_CONVOLUTION_ASSERT_SVH
`define SHRINK_THEN_LINEAR_CONVOLUTION_ASSERT_SVH
`ifndef SYNTHESIS
`define STLC_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define STLC_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define STLC_ASSERT_IMP(name, clk, rst, ante, cons)
`define STLC_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

### sv/stlc_pkg.sv
// Package for the shrink-then-convolve block: payload structs, codes and widths.
// No dependencies; used by every module of the block but the RAM.
`timescale 1ns / 1ps
package stlc_pkg;
   localparam int SAMPLE_WIDTH = 16;
   localparam int VALUE_W      = 37;
   localparam int IDX_W        = 6;
   localparam int CNT_W        = IDX_W + 1;
   localparam int LEN_W        = 6;
   localparam int DELTA_W      = 7;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 7;

   localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
   localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
   localparam logic [1:0] OP_RUN         = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_LENGTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHRINK_DELTA  = 2'd2;

   typedef struct packed {
      logic [1:0]                     operation;
      logic signed [SAMPLE_WIDTH-1:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] result_value;
      logic [IDX_W-1:0]          result_index;
      logic                      status;
      logic                      last;
   } rsp_type;

   typedef struct packed {
      logic [LEN_W-1:0]   first_length;
      logic [LEN_W-1:0]   second_length;
      logic [DELTA_W-1:0] shrink_delta;
   } cfg_type;

   typedef struct packed {
      logic             fold_vld;
      logic             fold_first;
      logic             conv_vld;
      logic             use_fold;
      logic             zero_a;
      logic             first_term;
      logic             last_term;
      logic [IDX_W-1:0] index;
      logic             last;
      logic             emit_err;
   } cmd_type;
endpackage

### sv/shrink_then_linear_convolution.sv
// Top level of the shrink-then-convolve block: CSRs, handshake, controller and datapath.
// Depends on stlc_pkg, stlc_ctrl, stlc_dpath and the assertion macro header.
//
// Usage: a request is taken at a clock edge where start is high and busy is low.
// Operation 0 and 1 load one sample into the first or second sequence at the
// next load position; busy stays low during a load.
// Operation 2 runs: results come out one per strobe on rsp_strobe / rsp_payload,
// indexes 0 .. la+lb-2, the last one marked. If shrink_delta exceeds la+lb a
// single status-1 result follows the setup state through the result register.
// Run sequence: a setup state, fold reads of samples 0 .. d when the clipped
// shrink delta d is nonzero, then the multiply-accumulate terms, one per cycle
// through the single multiplier and the one read port of each sample store, then
// the s1, s2 and result registers. Busy stays high until the final result is issued.
// CSR writes through csr_valid/csr_ready are always taken; write them while idle.
// Reset clears the load positions and sets the lengths to 1 and the delta to 0;
// the sample stores hold whatever was loaded. Results cannot be stalled.
`timescale 1ns / 1ps
`include "shrink_then_linear_convolution_assert.svh"
module shrink_then_linear_convolution import stlc_pkg::*; #(
   parameter int MAX_LENGTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_payload,
   output logic                  rsp_strobe,
   output rsp_type               rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);
   localparam int AW = $clog2(MAX_LENGTH);

   cfg_type       cfg_ff, cfg_in;
   logic          req_accept;
   logic          ctrl_busy, pipe_busy;
   cmd_type       cmd;
   logic          wr_first, wr_second;
   logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;

   assign csr_ready  = 1'b1;
   assign busy       = ctrl_busy || pipe_busy;
   assign req_accept = start && !busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FIRST_LENGTH:  cfg_in.first_length  = csr_data[LEN_W-1:0];
            CSR_SECOND_LENGTH: cfg_in.second_length = csr_data[LEN_W-1:0];
            CSR_SHRINK_DELTA:  cfg_in.shrink_delta  = csr_data[DELTA_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_length  <= LEN_W'(1);
         cfg_ff.second_length <= LEN_W'(1);
         cfg_ff.shrink_delta  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   stlc_ctrl #(.MAX_LENGTH(MAX_LENGTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .req       (req_payload),
      .cfg       (cfg_ff),
      .ctrl_busy (ctrl_busy),
      .cmd       (cmd),
      .wr_first  (wr_first),
      .wr_second (wr_second),
      .wr_addr   (wr_addr),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b)
   );

   stlc_dpath #(.MAX_LENGTH(MAX_LENGTH)) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .wr_first   (wr_first),
      .wr_second  (wr_second),
      .wr_addr    (wr_addr),
      .wr_data    (req_payload.sample),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b),
      .pipe_busy  (pipe_busy),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_payload)
   );

   `STLC_ASSERT_IMP(a_err_is_last, clock, reset, rsp_strobe && rsp_payload.status, rsp_payload.last)
   `STLC_ASSERT_IMP(a_rsp_from_busy, clock, reset, rsp_strobe, $past(busy))
   `STLC_ASSERT_NXT(a_run_sets_busy, clock, reset, req_accept && (req_payload.operation == OP_RUN), busy)
   `STLC_ASSERT_NXT(a_last_ends_run, clock, reset, rsp_strobe && rsp_payload.last, !rsp_strobe)
endmodule

### sv/stlc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module stlc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### sv/stlc_ctrl.sv
// Controller: load pointers, run setup, fold and convolution sequencing.
// Depends on stlc_pkg; drives the datapath through cmd_type commands.
`timescale 1ns / 1ps
module stlc_ctrl import stlc_pkg::*; #(
   parameter int MAX_LENGTH = 32,
   localparam int AW = $clog2(MAX_LENGTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  req_type       req,
   input  cfg_type       cfg,
   output logic          ctrl_busy,
   output cmd_type       cmd,
   output logic          wr_first,
   output logic          wr_second,
   output logic [AW-1:0] wr_addr,
   output logic [AW-1:0] rd_addr_a,
   output logic [AW-1:0] rd_addr_b
);
   localparam int LW = $clog2(MAX_LENGTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SETUP = 4'b0010,
      ST_FOLD  = 4'b0100,
      ST_CONV  = 4'b1000
   } state_type;

   function automatic logic [LW-1:0] eff_len(input logic [LEN_W-1:0] len);
      logic [LW-1:0] res;
      if (len == '0) begin
         res = LW'(1);
      end else if (int'(len) > MAX_LENGTH) begin
         res = LW'(MAX_LENGTH);
      end else begin
         res = LW'(len);
      end
      return res;
   endfunction

   state_type        state_ff, state_in;
   logic [AW-1:0]    pos_first_ff, pos_first_in;
   logic [AW-1:0]    pos_second_ff, pos_second_in;
   logic [LW-1:0]    la_ff, la_in, lb_ff, lb_in;
   logic [AW-1:0]    d_ff, d_in;
   logic             err_ff, err_in;
   logic [IDX_W-1:0] n_ff, n_in;
   logic [AW-1:0]    k_ff, k_in;

   logic [LW-1:0]    la_cfg, lb_cfg;
   logic [LW-1:0]    pos_first_p1, pos_second_p1;
   logic [7:0]       delta_w, lsum_w;
   logic [CNT_W-1:0] la_w, lb_w, n_w, k_w, d_w, n1_w;
   logic [CNT_W-1:0] lam1, lbm1, kmin_cur, kmin_nxt, kmax, total_m1, kd;
   logic             last_term, last_n, zero_a;

   assign la_cfg        = eff_len(cfg.first_length);
   assign lb_cfg        = eff_len(cfg.second_length);
   assign pos_first_p1  = LW'(pos_first_ff) + LW'(1);
   assign pos_second_p1 = LW'(pos_second_ff) + LW'(1);
   assign delta_w       = 8'(cfg.shrink_delta);
   assign lsum_w        = 8'(la_cfg) + 8'(lb_cfg);

   assign la_w     = CNT_W'(la_ff);
   assign lb_w     = CNT_W'(lb_ff);
   assign n_w      = CNT_W'(n_ff);
   assign k_w      = CNT_W'(k_ff);
   assign d_w      = CNT_W'(d_ff);
   assign n1_w     = n_w + CNT_W'(1);
   assign lam1     = la_w - CNT_W'(1);
   assign lbm1     = lb_w - CNT_W'(1);
   assign kmin_cur = (n_w >= lbm1) ? n_w - lbm1 : '0;
   assign kmin_nxt = (n1_w >= lbm1) ? n1_w - lbm1 : '0;
   assign kmax     = (n_w < lam1) ? n_w : lam1;
   assign total_m1 = la_w + lb_w - CNT_W'(2);
   assign kd       = k_w + d_w;
   assign zero_a   = (kd >= la_w);
   assign last_term = (k_w == kmax);
   assign last_n    = (n_w == total_m1);

   always_comb begin
      state_in      = state_ff;
      pos_first_in  = pos_first_ff;
      pos_second_in = pos_second_ff;
      la_in         = la_ff;
      lb_in         = lb_ff;
      d_in          = d_ff;
      err_in        = err_ff;
      n_in          = n_ff;
      k_in          = k_ff;
      cmd           = '0;
      wr_first      = 1'b0;
      wr_second     = 1'b0;
      wr_addr       = pos_first_ff;
      rd_addr_a     = '0;
      rd_addr_b     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req.operation)
                  OP_LOAD_FIRST: begin
                     wr_first     = 1'b1;
                     wr_addr      = pos_first_ff;
                     pos_first_in = (pos_first_p1 >= la_cfg) ? '0 : AW'(pos_first_p1);
                  end
                  OP_LOAD_SECOND: begin
                     wr_second     = 1'b1;
                     wr_addr       = pos_second_ff;
                     pos_second_in = (pos_second_p1 >= lb_cfg) ? '0 : AW'(pos_second_p1);
                  end
                  OP_RUN: begin
                     pos_first_in  = '0;
                     pos_second_in = '0;
                     la_in         = la_cfg;
                     lb_in         = lb_cfg;
                     err_in        = (delta_w > lsum_w);
                     if (delta_w == '0) begin
                        d_in = '0;
                     end else if (delta_w >= 8'(la_cfg)) begin
                        d_in = AW'(la_cfg - LW'(1));
                     end else begin
                        d_in = AW'(cfg.shrink_delta);
                     end
                     state_in = ST_SETUP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SETUP: begin
            k_in = '0;
            n_in = '0;
            if (err_ff) begin
               cmd.emit_err = 1'b1;
               state_in     = ST_IDLE;
            end else if (d_ff != '0) begin
               state_in = ST_FOLD;
            end else begin
               state_in = ST_CONV;
            end
         end
         ST_FOLD: begin
            cmd.fold_vld   = 1'b1;
            cmd.fold_first = (k_ff == '0);
            rd_addr_a      = k_ff;
            if (k_ff == d_ff) begin
               k_in     = '0;
               n_in     = '0;
               state_in = ST_CONV;
            end else begin
               k_in = k_ff + AW'(1);
            end
         end
         ST_CONV: begin
            cmd.conv_vld   = 1'b1;
            cmd.use_fold   = (k_ff == '0) && (d_ff != '0);
            cmd.zero_a     = zero_a;
            cmd.first_term = (k_w == kmin_cur);
            cmd.last_term  = last_term;
            cmd.index      = n_ff;
            cmd.last       = last_n;
            rd_addr_a      = zero_a ? '0 : AW'(kd);
            rd_addr_b      = AW'(n_w - k_w);
            if (last_term) begin
               if (last_n) begin
                  state_in = ST_IDLE;
               end else begin
                  n_in = n_ff + IDX_W'(1);
                  k_in = AW'(kmin_nxt);
               end
            end else begin
               k_in = k_ff + AW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_first_ff  <= '0;
         pos_second_ff <= '0;
      end else begin
         state_ff      <= state_in;
         pos_first_ff  <= pos_first_in;
         pos_second_ff <= pos_second_in;
      end
      la_ff  <= la_in;
      lb_ff  <= lb_in;
      d_ff   <= d_in;
      err_ff <= err_in;
      n_ff   <= n_in;
      k_ff   <= k_in;
   end

   assign ctrl_busy = (state_ff != ST_IDLE);
endmodule

### sv/stlc_dpath.sv
// Datapath: sample stores, fold accumulator, multiply-accumulate, result register.
// Depends on stlc_pkg and stlc_ram; steered by cmd_type from the controller.
`timescale 1ns / 1ps
module stlc_dpath import stlc_pkg::*; #(
   parameter int MAX_LENGTH = 32,
   localparam int AW = $clog2(MAX_LENGTH)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   input  logic                    wr_first,
   input  logic                    wr_second,
   input  logic [AW-1:0]           wr_addr,
   input  logic [SAMPLE_WIDTH-1:0] wr_data,
   input  logic [AW-1:0]           rd_addr_a,
   input  logic [AW-1:0]           rd_addr_b,
   output logic                    pipe_busy,
   output logic                    rsp_strobe,
   output rsp_type                 rsp
);
   localparam int SW = SAMPLE_WIDTH;
   localparam int FW = SW + $clog2(MAX_LENGTH);
   localparam int PW = 2 * SW;
   localparam logic signed [FW-1:0] FOLD_HI = FW'((64'sd1 <<< (SW - 1)) - 64'sd1);
   localparam logic signed [FW-1:0] FOLD_LO = ~FOLD_HI;

   logic [SW-1:0]             rd_a, rd_b;
   cmd_type                   s1_ff, s2_ff;
   logic signed [FW-1:0]      fold_acc_ff, fold_acc_in;
   logic signed [SW-1:0]      fold_sat, a_op, b_op;
   logic signed [PW-1:0]      prod_ff, prod_in;
   logic signed [VALUE_W-1:0] acc_ff, acc_in;
   logic                      rsp_vld_ff;
   rsp_type                   rsp_ff;

   stlc_ram #(.WIDTH(SW), .DEPTH(MAX_LENGTH)) u_first_ram (
      .clock   (clock),
      .wr_en   (wr_first),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_a),
      .rd_data (rd_a)
   );

   stlc_ram #(.WIDTH(SW), .DEPTH(MAX_LENGTH)) u_second_ram (
      .clock   (clock),
      .wr_en   (wr_second),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_b),
      .rd_data (rd_b)
   );

   assign fold_acc_in = s1_ff.fold_first ? FW'($signed(rd_a))
                                         : fold_acc_ff + FW'($signed(rd_a));

   always_comb begin
      if (fold_acc_ff > FOLD_HI) begin
         fold_sat = SW'(FOLD_HI);
      end else if (fold_acc_ff < FOLD_LO) begin
         fold_sat = SW'(FOLD_LO);
      end else begin
         fold_sat = SW'(fold_acc_ff);
      end
   end

   always_comb begin
      if (s1_ff.use_fold) begin
         a_op = fold_sat;
      end else if (s1_ff.zero_a) begin
         a_op = '0;
      end else begin
         a_op = $signed(rd_a);
      end
   end

   assign b_op    = $signed(rd_b);
   assign prod_in = a_op * b_op;
   assign acc_in  = s2_ff.first_term ? VALUE_W'(prod_ff) : acc_ff + VALUE_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff      <= '0;
         s2_ff      <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_ff      <= cmd;
         s2_ff      <= s1_ff;
         rsp_vld_ff <= cmd.emit_err || (s2_ff.conv_vld && s2_ff.last_term);
      end
      if (s1_ff.fold_vld) begin
         fold_acc_ff <= fold_acc_in;
      end
      prod_ff <= prod_in;
      if (s2_ff.conv_vld) begin
         acc_ff <= acc_in;
      end
      if (cmd.emit_err) begin
         rsp_ff.result_value <= '0;
         rsp_ff.result_index <= '0;
         rsp_ff.status       <= 1'b1;
         rsp_ff.last         <= 1'b1;
      end else begin
         rsp_ff.result_value <= acc_in;
         rsp_ff.result_index <= s2_ff.index;
         rsp_ff.status       <= 1'b0;
         rsp_ff.last         <= s2_ff.last;
      end
   end

   assign pipe_busy  = s1_ff.fold_vld || s1_ff.conv_vld || s2_ff.conv_vld;
   assign rsp_strobe = rsp_vld_ff;
   assign rsp        = rsp_ff;
endmodule

### dv/stlc_conv_checker.sv
// Checker for the shrink-then-convolve block: watches the request, result and CSR
// channels, predicts every result and compares it field by field.
// Depends on stlc_pkg.
`timescale 1ns / 1ps
module stlc_conv_checker import stlc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  req_type               req_payload,
   input  logic                  rsp_strobe,
   input  rsp_type               rsp_payload,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    pending
);
   localparam int     DEPTH      = 32;
   localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
   localparam longint VALUE_MAX  = (64'sd1 <<< (VALUE_W - 1)) - 1;

   logic signed [SAMPLE_WIDTH-1:0] first_mem  [DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] second_mem [DEPTH];
   int                             first_pos;
   int                             second_pos;
   logic [LEN_W-1:0]               length_a;
   logic [LEN_W-1:0]               length_b;
   logic [DELTA_W-1:0]             delta;
   rsp_type                        expected_samples [$];
   rsp_type                        want;

   function automatic int clamp_length(input logic [LEN_W-1:0] len);
      if (len == 0) return 1;
      if (len > DEPTH) return DEPTH;
      return int'(len);
   endfunction

   function automatic longint clip(input longint v, input longint hi);
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic store_sample(input bit to_first, input logic signed [SAMPLE_WIDTH-1:0] smp);
      int span;
      if (to_first) begin
         span = clamp_length(length_a);
         if (first_pos < DEPTH) first_mem[first_pos] = smp;
         first_pos = (first_pos + 1 >= span) ? 0 : first_pos + 1;
      end else begin
         span = clamp_length(length_b);
         if (second_pos < DEPTH) second_mem[second_pos] = smp;
         second_pos = (second_pos + 1 >= span) ? 0 : second_pos + 1;
      end
   endtask

   task automatic convolve_expected();
      int      la, lb, d, total, kmin, kmax, i, n, k;
      longint  fa [DEPTH];
      longint  acc;
      rsp_type r;
      la = clamp_length(length_a);
      lb = clamp_length(length_b);
      d  = int'(delta);
      if (d > la + lb) begin
         r        = '0;
         r.status = 1'b1;
         r.last   = 1'b1;
         expected_samples.push_back(r);
      end else begin
         for (i = 0; i < la; i++) fa[i] = first_mem[i];
         if (d != 0) begin
            if (d >= la) d = la - 1;
            acc = 0;
            for (i = 0; i <= d; i++) acc += fa[i];
            fa[0] = clip(acc, SAMPLE_MAX);
            for (i = 1; i + d < la; i++) fa[i] = fa[i + d];
            for (; i < la; i++) fa[i] = 0;
         end
         total = la + lb - 1;
         for (n = 0; n < total; n++) begin
            kmin = (n >= lb - 1) ? n - (lb - 1) : 0;
            kmax = (n < la - 1) ? n : la - 1;
            acc  = 0;
            for (k = kmin; k <= kmax; k++) acc += fa[k] * longint'(second_mem[n - k]);
            acc            = clip(acc, VALUE_MAX);
            r.result_value = acc[VALUE_W-1:0];
            r.result_index = n[IDX_W-1:0];
            r.status       = 1'b0;
            r.last         = (n == total - 1);
            expected_samples.push_back(r);
         end
      end
      first_pos  = 0;
      second_pos = 0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         first_pos  = 0;
         second_pos = 0;
         length_a   = 1;
         length_b   = 1;
         delta      = 0;
         expected_samples.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_samples.size() == 0) begin
               report_mismatch($sformatf("unexpected result: index %0d value %0d status %0d",
                  rsp_payload.result_index, rsp_payload.result_value, rsp_payload.status));
            end else begin
               want = expected_samples.pop_front();
               if (rsp_payload.result_value !== want.result_value)
                  report_mismatch($sformatf("index %0d: value %0d, expected %0d",
                     want.result_index, rsp_payload.result_value, want.result_value));
               if (rsp_payload.result_index !== want.result_index)
                  report_mismatch($sformatf("result_index %0d, expected %0d",
                     rsp_payload.result_index, want.result_index));
               if (rsp_payload.status !== want.status)
                  report_mismatch($sformatf("index %0d: status %0b, expected %0b",
                     want.result_index, rsp_payload.status, want.status));
               if (rsp_payload.last !== want.last)
                  report_mismatch($sformatf("index %0d: last %0b, expected %0b",
                     want.result_index, rsp_payload.last, want.last));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FIRST_LENGTH:  length_a = csr_data[LEN_W-1:0];
               CSR_SECOND_LENGTH: length_b = csr_data[LEN_W-1:0];
               CSR_SHRINK_DELTA:  delta    = csr_data[DELTA_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            case (req_payload.operation)
               OP_LOAD_FIRST:  store_sample(1'b1, req_payload.sample);
               OP_LOAD_SECOND: store_sample(1'b0, req_payload.sample);
               OP_RUN:         convolve_expected();
               default: ;
            endcase
         end
      end
      pending = expected_samples.size();
   end
endmodule

### dv/tb_shrink_then_linear_convolution.sv
// Testbench top for the shrink-then-convolve block: clock, reset, request and CSR
// stimulus, stall watchdog and verdict. Depends on stlc_pkg, stlc_conv_checker and
// the block itself.
`timescale 1ns / 1ps
module tb_shrink_then_linear_convolution;
   import stlc_pkg::*;

   localparam int         STALL_LIMIT  = 4000;
   localparam int         RANDOM_ITEMS = 450;
   localparam logic [1:0] OP_UNUSED    = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_payload;
   logic                  rsp_strobe;
   rsp_type               rsp_payload;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    fail_count;
   int                    pending;
   int                    max_gap;

   shrink_then_linear_convolution uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   stlc_conv_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int span_of(input int len);
      if (len == 0) return 1;
      if (len > 32) return 32;
      return len;
   endfunction

   function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'hffff;
         default: return SAMPLE_WIDTH'($urandom);
      endcase
   endfunction

   task automatic send_request(input logic [1:0] op, input logic [SAMPLE_WIDTH-1:0] smp);
      int      gap;
      req_type req;
      gap           = $urandom_range(0, max_gap);
      req.operation = op;
      req.sample    = smp;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start       <= 1'b1;
      req_payload <= req;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         csr_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic configure(input int la, input int lb, input int d);
      start <= 1'b0;
      write_register(CSR_FIRST_LENGTH, la[CSR_DATA_W-1:0]);
      write_register(CSR_SECOND_LENGTH, lb[CSR_DATA_W-1:0]);
      write_register(CSR_SHRINK_DELTA, d[CSR_DATA_W-1:0]);
      csr_valid <= 1'b0;
   endtask

   // loads leave no result, so wait for an empty result queue and an idle block, then settle
   task automatic wait_idle();
      start <= 1'b0;
      do @(negedge clock); while (pending != 0 || busy);
      repeat (8) @(negedge clock);
   endtask

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) quiet = 0;
         else quiet++;
      end
      $display("FAIL shrink_then_linear_convolution");
      $finish;
   end

   initial begin
      int la, lb, d, la_n, lb_n, nf, ns, done_items, phase, op;
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      max_gap     = 3;
      done_items  = 0;
      phase       = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, folding with saturation both ways, delta limits
      send_request(OP_UNUSED, 16'hffff);
      configure(2, 2, 0);
      send_request(OP_LOAD_FIRST, 16'h8000);
      send_request(OP_LOAD_FIRST, 16'h7fff);
      send_request(OP_LOAD_SECOND, 16'h8000);
      send_request(OP_LOAD_SECOND, 16'h8000);
      send_request(OP_RUN, 16'h0000);
      wait_idle();
      configure(2, 2, 1);
      send_request(OP_LOAD_FIRST, 16'h7fff);
      send_request(OP_LOAD_FIRST, 16'h7fff);
      send_request(OP_LOAD_SECOND, 16'h7fff);
      send_request(OP_LOAD_SECOND, 16'h0001);
      send_request(OP_RUN, 16'h7fff);
      wait_idle();
      configure(2, 2, 1);
      send_request(OP_LOAD_FIRST, 16'h8000);
      send_request(OP_LOAD_FIRST, 16'hffff);
      send_request(OP_LOAD_SECOND, 16'h0001);
      send_request(OP_LOAD_SECOND, 16'hffff);
      send_request(OP_RUN, 16'h8000);
      wait_idle();
      configure(2, 2, 5);
      send_request(OP_RUN, 16'h0000);
      wait_idle();
      configure(0, 0, 0);
      send_request(OP_LOAD_FIRST, 16'hffff);
      send_request(OP_LOAD_SECOND, 16'h5555);
      send_request(OP_RUN, 16'h0000);
      wait_idle();
      configure(0, 0, 2);
      send_request(OP_RUN, 16'h0000);
      wait_idle();
      configure(0, 0, 3);
      send_request(OP_RUN, 16'h0000);

      // random phases; the first one fills both stores completely
      while (done_items < RANDOM_ITEMS) begin
         wait_idle();
         case (phase)
            0: begin la = 32; lb = 32; d = 0;   end
            1: begin la = 32; lb = 32; d = 127; end
            2: begin la = 32; lb = 32; d = 31;  end
            3: begin la = 1;  lb = 32; d = 0;   end
            4: begin la = 32; lb = 1;  d = 40;  end
            5: begin la = 63; lb = 63; d = 64;  end
            6: begin la = 1;  lb = 1;  d = 127; end
            default: begin
               case ($urandom_range(0, 9))
                  0, 1: begin la = $urandom_range(1, 32); lb = $urandom_range(1, 32); end
                  2: begin
                     la = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(33, 63);
                     lb = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(33, 63);
                  end
                  default: begin la = $urandom_range(1, 8); lb = $urandom_range(1, 8); end
               endcase
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: d = 0;
                  4, 5, 6, 7: d = $urandom_range(1, 12);
                  default:    d = $urandom_range(0, 127);
               endcase
            end
         endcase
         max_gap = ($urandom_range(0, 9) < 3) ? 0 : 10;
         configure(la, lb, d);
         la_n = span_of(la);
         lb_n = span_of(lb);
         repeat ($urandom_range(1, 3)) begin
            if (phase == 0 || $urandom_range(0, 9) < 8) begin
               nf = la_n;
               ns = lb_n;
               while (nf + ns > 0) begin
                  if (ns == 0 || (nf > 0 && $urandom_range(0, 1) == 0)) begin
                     send_request(OP_LOAD_FIRST, pick_sample());
                     nf--;
                  end else begin
                     send_request(OP_LOAD_SECOND, pick_sample());
                     ns--;
                  end
               end
               send_request(OP_RUN, pick_sample());
               done_items += la_n + lb_n + 1;
            end else begin
               repeat ($urandom_range(1, 6)) begin
                  op = $urandom_range(0, 3);
                  send_request(op[1:0], pick_sample());
                  if (op[1:0] != OP_UNUSED) done_items++;
               end
            end
         end
         phase++;
      end

      wait_idle();
      repeat (40) @(negedge clock);
      if (fail_count == 0) $display("PASS shrink_then_linear_convolution");
      else $display("FAIL shrink_then_linear_convolution");
      $finish;
   end
endmodule
